FILE: rtl/hfa_pkg.sv
package hfa_pkg;

   // pool geometry
   localparam int POOL_SIZE = 64;
   localparam int HANDLE_W  = 6;
   localparam int COUNT_W   = $clog2(POOL_SIZE + 1);
   localparam int PTR_W     = $clog2(POOL_SIZE);

   // command codes
   localparam logic [1:0] CMD_ALLOC     = 2'd0;
   localparam logic [1:0] CMD_TRY_ALLOC = 2'd1;
   localparam logic [1:0] CMD_RELEASE   = 2'd2;

   // status codes
   localparam logic [1:0] STAT_OK          = 2'd0;
   localparam logic [1:0] STAT_NO_FREED    = 2'd1;
   localparam logic [1:0] STAT_EXHAUSTED   = 2'd2;
   localparam logic [1:0] STAT_BAD_RELEASE = 2'd3;

   // request payload
   typedef struct packed {
      logic [1:0]          command;
      logic [HANDLE_W-1:0] handle_in;
   } req_type;

   // response payload
   typedef struct packed {
      logic [HANDLE_W-1:0] handle_out;
      logic [1:0]          status;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic exec;
   } ctl_type;

endpackage

FILE: rtl/hfa_ctrl.sv
module hfa_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output hfa_pkg::ctl_type ctl
);
   import hfa_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;

   // handshake decode
   assign req_ready = (state_ff == ST_IDLE);
   assign ctl.load  = req_valid && req_ready;
   assign ctl.exec  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.load) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (ctl.exec) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output slot occupancy
   always_comb begin
      priority if (ctl.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/hfa_dpath.sv
module hfa_dpath (
   input  logic             clock,
   input  logic             reset,
   input  hfa_pkg::ctl_type ctl,
   input  hfa_pkg::req_type req_data,
   output hfa_pkg::rsp_type rsp_data
);
   import hfa_pkg::*;

   // free list storage, no reset
   logic [HANDLE_W-1:0] free_mem [POOL_SIZE];
   logic [HANDLE_W-1:0] rd_data_ff;

   req_type             req_ff;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;
   logic [PTR_W-1:0]    head_ff;
   logic [PTR_W-1:0]    head_in;
   logic [PTR_W-1:0]    tail_ff;
   logic [PTR_W-1:0]    tail_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;
   logic [COUNT_W-1:0]  fresh_ff;
   logic [COUNT_W-1:0]  fresh_in;
   logic [POOL_SIZE-1:0] map_ff;
   logic [POOL_SIZE-1:0] map_in;
   logic                push;

   // command update
   always_comb begin
      rsp_in   = '0;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      fresh_in = fresh_ff;
      map_in   = map_ff;
      push     = 1'b0;
      if (ctl.exec) begin
         unique case (req_ff.command)
            CMD_ALLOC, CMD_TRY_ALLOC: begin
               priority if (count_ff != '0) begin
                  rsp_in.handle_out = rd_data_ff;
                  head_in           = head_ff + PTR_W'(1);
                  count_in          = count_ff - COUNT_W'(1);
                  map_in[rd_data_ff[PTR_W-1:0]] = 1'b1;
               end else if (req_ff.command == CMD_TRY_ALLOC) begin
                  rsp_in.status = STAT_NO_FREED;
               end else if (fresh_ff < COUNT_W'(POOL_SIZE)) begin
                  rsp_in.handle_out = fresh_ff[HANDLE_W-1:0];
                  fresh_in          = fresh_ff + COUNT_W'(1);
                  map_in[fresh_ff[PTR_W-1:0]] = 1'b1;
               end else begin
                  rsp_in.status = STAT_EXHAUSTED;
               end
            end
            CMD_RELEASE: begin
               if (map_ff[req_ff.handle_in[PTR_W-1:0]]) begin
                  map_in[req_ff.handle_in[PTR_W-1:0]] = 1'b0;
                  if (count_ff < COUNT_W'(POOL_SIZE)) begin
                     push     = 1'b1;
                     tail_in  = tail_ff + PTR_W'(1);
                     count_in = count_ff + COUNT_W'(1);
                  end
               end else begin
                  rsp_in.status = STAT_BAD_RELEASE;
               end
            end
            default: rsp_in = '0;
         endcase
      end
   end

   // free list memory: one write port, registered read at head
   always_ff @(posedge clock) begin
      if (push) begin
         free_mem[tail_ff] <= req_ff.handle_in;
      end
      rd_data_ff <= free_mem[head_ff];
   end

   // request capture and result register
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff <= req_data;
      end
      if (ctl.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   // pointers, counters and allocation bitmap
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         fresh_ff <= '0;
         map_ff   <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         fresh_ff <= fresh_in;
         map_ff   <= map_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: rtl/fifo_free_list_handle_allocator.sv
// Handle allocator over a pool of 64 handles with a FIFO free list.
// Request channel (req_valid/req_ready/req_data) carries one command per
// transfer: allocate, try-allocate from released handles only, or release
// req_data.handle_in. Response channel (rsp_valid/rsp_ready/rsp_data)
// returns exactly one result per command: granted handle and status.
// A transferred request is captured, and its result is written into the
// response register in the exec state, once that register is free.
// No new command is taken before the last one is updated; the free-list memory read at the
// head pointer is registered ahead of the update cycle.
// While a result waits in the response register the next request is still
// taken; its update then holds until rsp_ready frees the register, and no
// further request is taken meanwhile.
// Reset clears the allocation bitmap, the free-list pointers and count and
// the fresh-handle counter; the free-list storage itself is not cleared and
// needs no clearing pass, so requests are taken right after reset.
module fifo_free_list_handle_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hfa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hfa_pkg::rsp_type rsp_data
);
   import hfa_pkg::*;

   ctl_type ctl;

   // sequencer
   hfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl)
   );

   // free list, bitmap and result register
   hfa_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // a commit always leaves a result waiting
   a_exec_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      ctl.exec |=> rsp_valid)
      else $error("commit did not raise rsp_valid");

   // one command in flight: a request transfer closes the request side
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another was in flight");

   // capture and commit never coincide
   a_load_exec_excl: assert property (@(posedge clock) disable iff (reset)
      !(ctl.load && ctl.exec))
      else $error("load and commit in the same cycle");

   // failed commands grant no handle
   a_fail_zero_handle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STAT_OK) |-> (rsp_data.handle_out == '0))
      else $error("nonzero handle on failed command");

endmodule

FILE: test/handle_grant_checker.sv
module handle_grant_checker
   import hfa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      outstanding
);

   // predicted allocator state
   rsp_type              expected_grants[$];
   logic [HANDLE_W-1:0]  freed_handles[$];
   logic [POOL_SIZE-1:0] issued_map;
   logic [COUNT_W-1:0]   fresh_next;
   int                   mismatches = 0;

   // apply one command to the predicted state, return the grant it yields
   function automatic rsp_type grant_or_release(input req_type item);
      rsp_type outcome;
      outcome.handle_out = '0;
      outcome.status     = STAT_OK;
      case (item.command)
         CMD_ALLOC, CMD_TRY_ALLOC: begin
            if (freed_handles.size() > 0) begin
               // oldest released handle goes out first
               outcome.handle_out = freed_handles.pop_front();
               issued_map[outcome.handle_out] = 1'b1;
            end else if (item.command == CMD_TRY_ALLOC) begin
               outcome.status = STAT_NO_FREED;
            end else if (fresh_next < POOL_SIZE) begin
               outcome.handle_out = fresh_next[HANDLE_W-1:0];
               issued_map[outcome.handle_out] = 1'b1;
               fresh_next = fresh_next + COUNT_W'(1);
            end else begin
               outcome.status = STAT_EXHAUSTED;
            end
         end
         CMD_RELEASE: begin
            if (issued_map[item.handle_in]) begin
               issued_map[item.handle_in] = 1'b0;
               if (freed_handles.size() < POOL_SIZE)
                  freed_handles.push_back(item.handle_in);
            end else begin
               outcome.status = STAT_BAD_RELEASE;
            end
         end
         default: ;
      endcase
      return outcome;
   endfunction

   // count a failure, print only the first few
   task automatic note_failure(input string what, input rsp_type want, input rsp_type seen);
      mismatches++;
      if (mismatches <= 10)
         $display("%s: expected handle %0d status %0d, got handle %0d status %0d",
                  what, want.handle_out, want.status, seen.handle_out, seen.status);
   endtask

   // compare result transfers first, then queue the prediction for a new request
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_grants.delete();
         freed_handles.delete();
         issued_map = '0;
         fresh_next = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_grants.size() == 0) begin
               want = '0;
               note_failure("unexpected result transfer", want, rsp_data);
            end else begin
               want = expected_grants.pop_front();
               if (rsp_data.handle_out !== want.handle_out)
                  note_failure("handle_out mismatch", want, rsp_data);
               else if (rsp_data.status !== want.status)
                  note_failure("status mismatch", want, rsp_data);
            end
         end
         if (req_valid && req_ready)
            expected_grants.push_back(grant_or_release(req_data));
      end
      fail_count  <= mismatches;
      outstanding <= expected_grants.size();
   end

endmodule

FILE: test/tb_fifo_free_list_handle_allocator.sv
module tb_fifo_free_list_handle_allocator;
   import hfa_pkg::*;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         RANDOM_ITEMS = 1650;
   localparam int         RUN_LIMIT    = 8000000;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_NOISE} mix_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      fail_count;
   int      outstanding;

   // stimulus steering: handles seen granted, commands awaiting their result
   logic [1:0]          pending_cmds[$];
   logic [HANDLE_W-1:0] granted[$];
   logic [HANDLE_W-1:0] last_released = '0;
   logic                gaps_on = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   fifo_free_list_handle_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   handle_grant_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // hard stop
   initial begin
      #(RUN_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // track granted handles at the falling edge so release targets are known
   always @(negedge clock) begin
      logic [1:0] cmd;
      if (reset) begin
         pending_cmds.delete();
         granted.delete();
      end else begin
         if (req_valid && req_ready)
            pending_cmds.push_back(req_data.command);
         if (rsp_valid && rsp_ready && pending_cmds.size() > 0) begin
            cmd = pending_cmds.pop_front();
            if ((cmd == CMD_ALLOC || cmd == CMD_TRY_ALLOC) && rsp_data.status == STAT_OK)
               granted.push_back(rsp_data.handle_out);
         end
      end
   end

   // receiver back-pressure: stretches of steady, choppy, starved and long-stall modes
   initial begin
      int mode;
      int stretch;
      int hold;
      hold = 0;
      rsp_ready = 1'b0;
      forever begin
         mode    = $urandom_range(0, 3);
         stretch = $urandom_range(10, 80);
         repeat (stretch) begin
            @(posedge clock);
            if (hold > 0) begin
               hold--;
               rsp_ready <= 1'b0;
            end else begin
               case (mode)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= ($urandom_range(0, 9) < 7);
                  2: rsp_ready <= ($urandom_range(0, 9) < 3);
                  default: begin
                     if ($urandom_range(0, 19) == 0)
                        hold = $urandom_range(5, 30);
                     rsp_ready <= (hold == 0);
                  end
               endcase
            end
         end
      end
   end

   // sender gap: mostly none or short, a few long
   task automatic idle_gap();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         n = 0;
      else if (pick < 92)
         n = $urandom_range(1, 3);
      else
         n = $urandom_range(5, 30);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // drive one command and return at the edge of its transfer, valid left high
   task automatic send_command(input logic [1:0] cmd, input logic [HANDLE_W-1:0] h);
      req_type item;
      if (gaps_on)
         idle_gap();
      item.command   = cmd;
      item.handle_in = h;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // release a handle currently held, or a random one when none is held
   task automatic release_held();
      int idx;
      logic [HANDLE_W-1:0] h;
      if (granted.size() > 0) begin
         idx = $urandom_range(0, granted.size() - 1);
         h   = granted[idx];
         granted.delete(idx);
      end else begin
         h = HANDLE_W'($urandom);
      end
      last_released = h;
      send_command(CMD_RELEASE, h);
   endtask

   // hold off the sender until every result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      mix_type mix;
      int      sent;
      int      len;
      int      pick;
      logic [1:0] cmd;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed opening: empty list, fresh grants, bad releases, FIFO reuse order
      send_command(CMD_TRY_ALLOC, 6'd0);
      send_command(CMD_ALLOC, 6'd63);
      send_command(CMD_ALLOC, 6'd0);
      send_command(CMD_RELEASE, 6'd63);
      send_command(CMD_RELEASE, 6'd0);
      send_command(CMD_RELEASE, 6'd0);
      send_command(CMD_UNUSED, 6'h2a);
      send_command(CMD_UNUSED, 6'h15);
      send_command(CMD_TRY_ALLOC, 6'd0);
      send_command(CMD_RELEASE, 6'd1);
      send_command(CMD_RELEASE, 6'd0);
      send_command(CMD_ALLOC, 6'd0);
      send_command(CMD_TRY_ALLOC, 6'd63);
      send_command(CMD_TRY_ALLOC, 6'd0);
      send_command(CMD_ALLOC, 6'd0);
      send_command(CMD_RELEASE, 6'd2);
      send_command(CMD_RELEASE, 6'd1);
      send_command(CMD_RELEASE, 6'd0);
      send_command(CMD_ALLOC, 6'd0);
      send_command(CMD_ALLOC, 6'd0);
      send_command(CMD_ALLOC, 6'd0);
      send_command(CMD_RELEASE, 6'd3);
      wait_drained();

      // random phases with different command mixes
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         mix     = mix_type'($urandom_range(0, 3));
         len     = $urandom_range(40, 160);
         gaps_on = ($urandom_range(0, 3) != 0);
         repeat (len) begin
            if (sent < RANDOM_ITEMS) begin
               pick = $urandom_range(0, 99);
               cmd  = CMD_RELEASE;
               case (mix)
                  MIX_FILL: begin
                     if (pick < 70) cmd = CMD_ALLOC;
                     else if (pick < 85) cmd = CMD_TRY_ALLOC;
                  end
                  MIX_DRAIN: begin
                     if (pick >= 65 && pick < 80) cmd = CMD_TRY_ALLOC;
                     else if (pick >= 80 && pick < 92) cmd = CMD_ALLOC;
                  end
                  MIX_BALANCED: begin
                     if (pick < 35) cmd = CMD_ALLOC;
                     else if (pick < 55) cmd = CMD_TRY_ALLOC;
                  end
                  default: cmd = 2'($urandom_range(0, 3));
               endcase
               if (mix == MIX_NOISE)
                  send_command(cmd, HANDLE_W'($urandom));
               else if (cmd != CMD_RELEASE)
                  send_command(cmd, HANDLE_W'($urandom));
               else if (pick >= 92 || (mix == MIX_BALANCED && pick >= 90))
                  send_command(CMD_RELEASE, last_released);
               else
                  release_held();
               if (cmd != CMD_UNUSED)
                  sent++;
            end
         end
         if ($urandom_range(0, 2) == 0)
            wait_drained();
      end

      // wind down and give the verdict
      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: files.f
rtl/hfa_pkg.sv
rtl/hfa_ctrl.sv
rtl/hfa_dpath.sv
rtl/fifo_free_list_handle_allocator.sv
test/handle_grant_checker.sv
test/tb_fifo_free_list_handle_allocator.sv
